### hdl/fpa_pkg.sv
// Package for the fixed-point ALU: opcode codes.
// No dependencies.
package fpa_pkg;
	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_MIN = 4'd4, OP_MAX = 4'd5, OP_INCR = 4'd6, OP_DECR = 4'd7,
		OP_I2F = 4'd8, OP_F2I = 4'd9
	} op_t;
endpackage

### hdl/fixed_point_alu.sv
// Top level of the fixed-point ALU: pipeline, multiply and divide datapaths.
// Depends on fpa_pkg.
//
// Usage: input words arrive on s_axis (tuser = req_type, tdata = operand_a,
// operand_b); one result word per input leaves on m_axis.
// The pipeline is a fixed chain of STAGES registers; every stage advances when
// the output stage is empty or being taken, so one word per cycle flows
// through. A result word is valid on m_axis once its input word has passed
// through every stage of the chain.
// Depth is set by the divider, one quotient bit per stage over 33+FRAC_BITS
// bits of magnitude quotient, followed by sign and saturation stages.
// Multiply is split into four 16x16 partial products across the early stages.
// When the receiver stalls, every stage holds; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// s_axis_tready is high whenever the output stage can move.
module fixed_point_alu #(
	parameter int FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: [31:0] operand_a, [63:32] operand_b
	input  logic [63:0] s_axis_tdata,
	// tuser: [3:0] req_type
	input  logic [3:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: [31:0] result_value, [32] a_greater, [33] a_less, [34] a_equal,
	// [35] overflow_flag, [36] divide_by_zero, [39:37] zero
	output logic [39:0] m_axis_tdata
);
	import fpa_pkg::*;

	localparam int QW = 32 + FRAC_BITS + 1; // quotient bits of 2*num/(2*den) form
	localparam int NW = QW + 1;             // numerator width: 2*|a|<<F + |b|
	localparam int STAGES = QW + 3;

	typedef struct packed {
		logic [3:0]        op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic               neg;
		logic               gt, lt, eq;
		logic [63:0]        prod;
		logic [NW-1:0]      rem;   // divider running remainder/numerator
		logic [QW-1:0]      quo;
		logic [32:0]        den;   // 2*|b|
	} stg_t;

	// payload for every stage but the last; the last stage holds out_s1
	stg_t st_s1 [STAGES-1];
	logic v_s1 [STAGES];
	logic adv;

	assign adv = !v_s1[STAGES-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = v_s1[STAGES-1];

	// stage 0 entry: magnitudes, flags, high-high and low-low partial products
	stg_t ent;
	logic [31:0] ma, mb;
	always_comb begin
		ent = '0;
		ent.op = s_axis_tuser;
		ent.a = s_axis_tdata[31:0];
		ent.b = s_axis_tdata[63:32];
		ent.gt = ent.a > ent.b;
		ent.lt = ent.a < ent.b;
		ent.eq = ent.a == ent.b;
		ent.neg = ent.a[31] ^ ent.b[31];
		ma = ent.a[31] ? 32'(-ent.a) : 32'(ent.a);
		mb = ent.b[31] ? 32'(-ent.b) : 32'(ent.b);
		// division numerator: 2*|a|<<F + |b|, denominator 2*|b|
		ent.rem = NW'({1'b0, ma} << (FRAC_BITS + 1)) + NW'(mb);
		ent.den = {mb, 1'b0};
		// high-high and low-low partial products now, mixed products added in the next stage
		ent.prod = {32'(ma[31:16] * mb[31:16]), 32'(ma[15:0] * mb[15:0])};
	end

	// mixed products kept per stage-1 slot
	logic [31:0] pm_s1, pn_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			pm_s1 <= 32'(ma[31:16] * mb[15:0]);
			pn_s1 <= 32'(ma[15:0] * mb[31:16]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STAGES; i++) v_s1[i] <= 1'b0;
		end else if (adv) begin
			v_s1[0] <= s_axis_tvalid;
			for (int i = 1; i < STAGES; i++) v_s1[i] <= v_s1[i-1];
		end
	end

	// restoring divider: one quotient bit per stage, MSB first
	always_ff @(posedge clk) begin
		stg_t nxt;
		if (adv) begin
			st_s1[0] <= ent;
			for (int i = 1; i < STAGES-1; i++) begin
				nxt = st_s1[i-1];
				if (i == 1)
					nxt.prod = st_s1[0].prod
						+ {16'd0, pm_s1, 16'd0} + {16'd0, pn_s1, 16'd0};
				if (i <= QW) begin
					if ((st_s1[i-1].rem >> (QW - i)) >= NW'(st_s1[i-1].den)) begin
						nxt.rem = st_s1[i-1].rem
							- (NW'(st_s1[i-1].den) << (QW - i));
						nxt.quo = st_s1[i-1].quo | (QW'(1) << (QW - i));
					end
				end
				st_s1[i] <= nxt;
			end
		end
	end

	// output stage: select and saturate
	stg_t fin;
	logic [31:0] res_q;
	logic ovf_q, dbz_q;
	logic [63:0] mag;
	logic signed [33:0] sum;
	always_comb begin
		fin = st_s1[STAGES-2];
		res_q = '0; ovf_q = 1'b0; dbz_q = 1'b0; mag = '0; sum = '0;
		case (op_t'(fin.op))
			OP_ADD: sum = 34'(fin.a) + 34'(fin.b);
			OP_SUB: sum = 34'(fin.a) - 34'(fin.b);
			OP_INCR: sum = 34'(fin.a) + 34'sd1;
			OP_DECR: sum = 34'(fin.a) - 34'sd1;
			default: sum = '0;
		endcase
		case (op_t'(fin.op))
			OP_ADD, OP_SUB, OP_INCR, OP_DECR: begin
				if (sum > 34'sh7FFFFFFF) begin res_q = 32'h7FFFFFFF; ovf_q = 1'b1; end
				else if (sum < -34'sh80000000) begin res_q = 32'h80000000; ovf_q = 1'b1; end
				else res_q = sum[31:0];
			end
			OP_I2F: begin
				if (fin.a > (32'sh7FFFFFFF >>> FRAC_BITS)) begin
					res_q = 32'h7FFFFFFF; ovf_q = 1'b1;
				end else if (fin.a < (-32'sh80000000 >>> FRAC_BITS)) begin
					res_q = 32'h80000000; ovf_q = 1'b1;
				end else res_q = 32'(fin.a <<< FRAC_BITS);
			end
			OP_F2I: res_q = 32'(fin.a >>> FRAC_BITS);
			OP_MIN: res_q = fin.lt ? fin.a : fin.b;
			OP_MAX: res_q = fin.gt ? fin.a : fin.b;
			OP_MUL, OP_DIV: begin
				if (op_t'(fin.op) == OP_MUL)
					mag = (fin.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
				else
					mag = 64'(fin.quo);
				if (op_t'(fin.op) == OP_DIV && fin.b == 0) begin
					dbz_q = 1'b1;
				end else if (mag > (fin.neg ? 64'h80000000 : 64'h7FFFFFFF)) begin
					ovf_q = 1'b1;
					res_q = fin.neg ? 32'h80000000 : 32'h7FFFFFFF;
				end else res_q = fin.neg ? 32'(-mag[31:0]) : mag[31:0];
			end
			default: res_q = '0;
		endcase
	end

	logic [39:0] out_s1;
	always_ff @(posedge clk) begin
		if (adv) out_s1 <= {3'b000, dbz_q, ovf_q, fin.eq, fin.lt, fin.gt, res_q};
	end
	assign m_axis_tdata = out_s1;
endmodule
